// ===== rtl/lst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

  // config register indexes
  localparam logic REG_MAX_JUMP   = 1'b0;
  localparam logic REG_MIN_ACTIVE = 1'b1;

  localparam int MAX_JUMP_W   = 12;
  localparam int MIN_ACTIVE_W = 4;
  localparam int CFG_DATA_W   = 12;
  localparam int JUMP_FRAC    = 8;   // max_jump is always unsigned Q4.8

  localparam int POS_OUT_W = 12;
  localparam int FWD_W     = 3;
  localparam int GLITCH_W  = 2;
  localparam int COUNT_W   = 4;
  localparam int LEVEL_W   = 4;
  localparam int SIDE_W    = 5;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // forward glitch filter states
  localparam logic [GLITCH_W-1:0] GL_NORMAL  = 2'd0;
  localparam logic [GLITCH_W-1:0] GL_SUSPECT = 2'd1;
  localparam logic [GLITCH_W-1:0] GL_WAIT    = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_DIV   = 6'b000100,
    S_DIFF  = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/line_sensor_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line sensor tracker. Each input word is one sensor sample; each one gives
// exactly one output word with the updated lateral position, the filtered
// forward value, the glitch filter state, the lit side-sensor count and the
// integer level of 4 + position. The block works on one sample at a time:
// the side sensors are summed one weight per cycle, the average comes from
// a restoring divider that yields one quotient bit per cycle, the jump test
// runs in the S_DIFF and S_CHECK states, and the result is then loaded into
// the output register once that register is free. When too few sensors are
// lit, the divider and the jump test are skipped and the position is held.
// The next sample can be taken in the cycle after the output register is loaded.
// s_tready is high only while the block is idle; a finished word waits in
// the output register while the next sample is accepted.
// Config writes must happen only while the block is idle.
module line_sensor_tracker_unit #(
  parameter int FRAC_BITS = 8
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                cfg_we,
  input  wire  logic                                cfg_addr,
  input  wire  logic [lst_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire  logic                                s_tvalid,
  output logic                                      s_tready,
  // [1:0] forward_bits, [6:2] left_bits, [11:7] right_bits, [15:12] zero
  input  wire  logic [lst_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                      m_tvalid,
  input  wire  logic                                m_tready,
  // [11:0] line_position, [14:12] forward_line, [16:15] glitch_state,
  // [20:17] active_count, [24:21] debug_level, [31:25] zero
  output logic [lst_pkg::OUT_TDATA_W-1:0]           m_tdata
);

  localparam int PW   = FRAC_BITS + 4;           // position / quotient width
  localparam int DW   = PW + 1;                  // difference width
  localparam int ITW  = $clog2(PW);
  localparam int CMPW = FRAC_BITS + lst_pkg::MAX_JUMP_W + 1 + lst_pkg::JUMP_FRAC;

  lst_pkg::state_t state;

  logic [lst_pkg::MAX_JUMP_W-1:0]   max_jump;
  logic [lst_pkg::MIN_ACTIVE_W-1:0] min_active;

  logic signed [PW-1:0]                 position;
  logic signed [lst_pkg::FWD_W-1:0]     forward;
  logic [lst_pkg::GLITCH_W-1:0]         glitch;

  logic [lst_pkg::SIDE_W-1:0]   left_sh;
  logic [lst_pkg::SIDE_W-1:0]   right_sh;
  logic [2:0]                   k;
  logic [lst_pkg::COUNT_W-1:0]  count;
  logic signed [4:0]            total;
  logic                         neg;
  logic [PW-1:0]                quo;
  logic [lst_pkg::COUNT_W-1:0]  rem;
  logic [ITW-1:0]               iter;
  logic signed [PW-1:0]         avg;
  logic signed [DW-1:0]         diff;

  // ---------------- forward glitch filter ----------------
  function automatic logic crosses(input logic signed [2:0] held,
                                   input logic signed [2:0] fresh);
    crosses = (held >= 3'sd2 && fresh < 3'sd0) || (held <= -3'sd2 && fresh > 3'sd0);
  endfunction

  logic [1:0]             fb;
  logic signed [2:0]      fresh;
  logic [lst_pkg::GLITCH_W-1:0] glitch_next;
  logic signed [2:0]      forward_next;
  logic [lst_pkg::GLITCH_W-1:0] g1;

  assign fb    = s_tdata[1:0];
  assign fresh = $signed({2'b00, fb[0]}) - $signed({2'b00, fb[1]});

  always_comb begin
    g1 = glitch;
    if (g1 == lst_pkg::GL_SUSPECT && fresh == 3'sd0) begin
      g1 = (fb == 2'b00) ? lst_pkg::GL_NORMAL : lst_pkg::GL_WAIT;
    end
    if (g1 == lst_pkg::GL_WAIT && crosses(forward, fresh)) begin
      g1 = lst_pkg::GL_SUSPECT;
    end
    glitch_next  = g1;
    forward_next = forward;
    if (fb != 2'b00 && g1 == lst_pkg::GL_NORMAL) begin
      if (crosses(forward, fresh)) begin
        glitch_next = lst_pkg::GL_SUSPECT;
      end else begin
        forward_next = fresh;
      end
    end else if (forward < 3'sd0) begin
      forward_next = -3'sd2;
    end else if (forward > 3'sd0) begin
      forward_next = 3'sd2;
    end
  end

  // ---------------- serial side-sensor sum ----------------
  logic [2:0]                  weight;
  logic [lst_pkg::COUNT_W-1:0] count_step;
  logic signed [4:0]           total_step;
  logic [3:0]                  mag_step;
  logic                        do_div;

  assign weight = 3'd4 - k;

  always_comb begin
    count_step = count + lst_pkg::COUNT_W'(right_sh[0]) + lst_pkg::COUNT_W'(left_sh[0]);
    case ({right_sh[0], left_sh[0]})
      2'b10:   total_step = total + $signed({2'b00, weight});
      2'b01:   total_step = total - $signed({2'b00, weight});
      default: total_step = total;
    endcase
    mag_step = total_step[4] ? 4'(-total_step) : 4'(total_step);
    do_div   = (count_step != '0) && (count_step > min_active);
  end

  // ---------------- divider step ----------------
  logic [lst_pkg::COUNT_W:0] rem_sh;
  logic                      qbit;

  assign rem_sh = {rem, quo[PW-1]};
  assign qbit   = (rem_sh >= {1'b0, count});

  // ---------------- jump test ----------------
  logic [DW-1:0]   abs_diff;
  logic [CMPW-1:0] lhs;
  logic [CMPW-1:0] rhs;

  assign abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign lhs = CMPW'(abs_diff) << lst_pkg::JUMP_FRAC;
  assign rhs = CMPW'(max_jump) << FRAC_BITS;

  // ---------------- output word ----------------
  logic [PW-1:0]                 level_sum;
  logic [lst_pkg::LEVEL_W-1:0]   level;
  logic [lst_pkg::POS_OUT_W-1:0] pos_out;
  logic                          out_load;

  assign level_sum = PW'(position) + (PW'(1) << (FRAC_BITS + 2));
  assign level     = level_sum[FRAC_BITS +: lst_pkg::LEVEL_W];
  assign pos_out   = lst_pkg::POS_OUT_W'(position);
  assign out_load  = (state == lst_pkg::S_OUT) && (!m_tvalid || m_tready);

  assign s_tready = (state == lst_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lst_pkg::S_IDLE;
      max_jump   <= lst_pkg::MAX_JUMP_W'(768);
      min_active <= lst_pkg::MIN_ACTIVE_W'(1);
      position   <= '0;
      forward    <= '0;
      glitch     <= lst_pkg::GL_NORMAL;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          lst_pkg::REG_MAX_JUMP:   max_jump   <= cfg_wdata[lst_pkg::MAX_JUMP_W-1:0];
          lst_pkg::REG_MIN_ACTIVE: min_active <= cfg_wdata[lst_pkg::MIN_ACTIVE_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        lst_pkg::S_IDLE: begin
          if (s_tvalid) begin
            forward  <= forward_next;
            glitch   <= glitch_next;
            left_sh  <= s_tdata[6:2];
            right_sh <= s_tdata[11:7];
            k        <= '0;
            count    <= '0;
            total    <= '0;
            state    <= lst_pkg::S_SUM;
          end
        end
        lst_pkg::S_SUM: begin
          count    <= count_step;
          total    <= total_step;
          left_sh  <= left_sh >> 1;
          right_sh <= right_sh >> 1;
          k        <= k + 3'd1;
          if (k == 3'd4) begin
            neg  <= total_step[4];
            quo  <= PW'(mag_step) << FRAC_BITS;
            rem  <= '0;
            iter <= '0;
            state <= do_div ? lst_pkg::S_DIV : lst_pkg::S_OUT;
          end
        end
        lst_pkg::S_DIV: begin
          rem  <= qbit ? lst_pkg::COUNT_W'(rem_sh - {1'b0, count})
                       : lst_pkg::COUNT_W'(rem_sh);
          quo  <= {quo[PW-2:0], qbit};
          iter <= iter + 1'b1;
          if (iter == ITW'(PW - 1)) begin
            state <= lst_pkg::S_DIFF;
          end
        end
        lst_pkg::S_DIFF: begin
          avg   <= neg ? -$signed(quo) : $signed(quo);
          diff  <= (neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}))
                   - DW'(position);
          state <= lst_pkg::S_CHECK;
        end
        lst_pkg::S_CHECK: begin
          if (lhs < rhs) begin
            position <= avg;
          end
          state <= lst_pkg::S_OUT;
        end
        lst_pkg::S_OUT: begin
          if (out_load) begin
            m_tdata  <= {7'd0, level, count, glitch, forward, pos_out};
            state    <= lst_pkg::S_IDLE;
          end
        end
        default: state <= lst_pkg::S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
